// File: rtl/jefd_pkg.sv
// Package for the JPEG entropy fragment detector: widths, byte codes and the
// candidate record passed from the front part to the back part. No dependencies.
`timescale 1ns / 1ps

package jefd_pkg;

	// Widths of the disk offset arithmetic and of the in-region byte counters.
	localparam int OFFSET_BITS = 48;
	localparam int REGION_BITS = 32;

	// Fixed field widths of the stream ports.
	localparam int BYTE_W   = 8;
	localparam int START_W  = 48;
	localparam int LENGTH_W = 32;
	localparam int MINLEN_W = 32;
	localparam int IN_TDATA_W  = BYTE_W + START_W;
	localparam int OUT_TDATA_W = START_W + LENGTH_W;

	// Width used to compare a stretch length against the minimum.
	localparam int CMP_BITS = (REGION_BITS > MINLEN_W) ? REGION_BITS : MINLEN_W;

	// Byte codes of the scan data syntax.
	localparam logic [BYTE_W-1:0] MARK_PREFIX   = 8'hFF;
	localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;
	localparam logic [BYTE_W-1:0] RESTART_FIRST = 8'hD0;
	localparam logic [BYTE_W-1:0] RESTART_END   = 8'hD8;

	localparam logic [MINLEN_W-1:0] MIN_FRAG_RESET = MINLEN_W'(64 * 1024);

	// Depth of the queue between the front and the back.
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCOUNT_BITS = $clog2(QDEPTH + 1);

	// One classified byte that may close a stretch: a marker break candidate,
	// a region tail candidate, or both.
	typedef struct packed {
		logic [OFFSET_BITS-1:0] base;
		logic                   mark_ok;
		logic [REGION_BITS-1:0] mark_begin;
		logic [REGION_BITS-1:0] brk_len;
		logic                   tail_ok;
		logic [REGION_BITS-1:0] tail_begin;
		logic [REGION_BITS-1:0] tail_len;
	} frag_cand_t;

endpackage

// File: rtl/jpeg_entropy_fragment_detector.sv
// Top level of the JPEG entropy fragment detector: joins the front part, the
// candidate queue and the back part. Depends on jefd_pkg and the three submodules.
`timescale 1ns / 1ps

// Usage
// The slave stream carries one byte of an unallocated disk region per word.
// The absolute offset of the region comes with every word but is sampled only
// on the first word of a region; tlast marks the final byte of the region, and
// the next word starts a new region. The master stream carries one word per
// reported fragment: its absolute start, its length and, in tuser, whether it
// was closed by the region end (1) or by an invalid marker (0).
// The minimum length is written through cfg_wr_en / cfg_wr_data while the block
// is idle; a stretch must be strictly longer than it to be reported.
// Throughput is one byte per cycle while a queue slot is free. The front part
// updates the scan state in the accepting cycle and queues a candidate; the back
// part pops it, applies the length check, adds the base and loads the result
// into the output register.
// When the receiver stalls, the output register holds its word and the four
// entry queue absorbs further candidates; tready drops only when it is full.
// Reset clears the scan state, empties the queue and output, and sets the
// minimum length to 65536.
module jpeg_entropy_fragment_detector
	import jefd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [MINLEN_W-1:0]    cfg_wr_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata fields from bit 0 up: data_byte [7:0], region_base [55:8].
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// tlast is region_end.
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata fields from bit 0 up: frag_start [47:0], frag_length [79:48].
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// tuser field: is_tail [0].
	output logic                   m_axis_tuser
);

	logic                in_accept;
	logic                q_push;
	logic                q_full;
	logic                q_pop;
	logic                q_valid;
	frag_cand_t          front_cand;
	frag_cand_t          q_cand;
	logic [START_W-1:0]  frag_start;
	logic [LENGTH_W-1:0] frag_length;

	// The front may take a byte whenever a queue slot is free.
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	jefd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_accept   (in_accept),
		.data_byte   (s_axis_tdata[BYTE_W-1:0]),
		.region_base (s_axis_tdata[IN_TDATA_W-1:BYTE_W]),
		.region_end  (s_axis_tlast),
		.push        (q_push),
		.cand        (front_cand)
	);

	jefd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_cand  (front_cand),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_cand  (q_cand)
	);

	jefd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rd_valid    (q_valid),
		.rd_cand     (q_cand),
		.pop         (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_start   (frag_start),
		.out_length  (frag_length),
		.out_tail    (m_axis_tuser)
	);

	assign m_axis_tdata = {frag_length, frag_start};

endmodule

// File: rtl/jefd_front.sv
// Front part of the fragment detector: tracks the scan state of the region
// and produces stretch candidates. Depends on jefd_pkg.
`timescale 1ns / 1ps

module jefd_front
	import jefd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_accept,
	input  logic [BYTE_W-1:0]      data_byte,
	input  logic [START_W-1:0]     region_base,
	input  logic                   region_end,
	output logic                   push,
	output frag_cand_t             cand
);

	logic [REGION_BITS-1:0] byte_index_q;
	logic [OFFSET_BITS-1:0] base_q;
	logic                   skip_q;
	logic [REGION_BITS-1:0] begin_q;
	logic                   prev_ff_q;
	logic [REGION_BITS-1:0] last_nz_end_q;

	logic [REGION_BITS-1:0] idx_plus1;
	logic [OFFSET_BITS-1:0] base_cur;
	logic                   is_zero;
	logic                   is_ff;
	logic                   is_rst;
	logic                   brk;
	logic                   skip_next;
	logic [REGION_BITS-1:0] begin_next;
	logic [REGION_BITS-1:0] tail_end;

	always_comb begin
		idx_plus1 = byte_index_q + REGION_BITS'(1);
		base_cur  = (byte_index_q == '0) ? OFFSET_BITS'(region_base) : base_q;
		is_zero   = (data_byte == STUFF_BYTE);
		is_ff     = (data_byte == MARK_PREFIX);
		is_rst    = (data_byte >= RESTART_FIRST) && (data_byte < RESTART_END);
		brk       = !skip_q && prev_ff_q && !is_zero && !is_rst;
		skip_next = skip_q && is_zero;
		if (skip_q) begin
			begin_next = is_zero ? idx_plus1 : begin_q;
		end else if (brk) begin
			begin_next = byte_index_q;
		end else begin
			begin_next = begin_q;
		end
		// End of the tail after dropping trailing zero bytes.
		tail_end = is_zero ? last_nz_end_q : idx_plus1;

		cand.base       = base_cur;
		cand.mark_ok    = brk;
		cand.mark_begin = begin_q;
		cand.brk_len    = byte_index_q - REGION_BITS'(1) - begin_q;
		cand.tail_ok    = region_end && !skip_next;
		cand.tail_begin = begin_next;
		cand.tail_len   = tail_end - begin_next;
		push            = in_accept && (cand.mark_ok || cand.tail_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q  <= '0;
			base_q        <= '0;
			skip_q        <= 1'b1;
			begin_q       <= '0;
			prev_ff_q     <= 1'b0;
			last_nz_end_q <= '0;
		end else if (in_accept) begin
			base_q <= base_cur;
			if (region_end) begin
				byte_index_q  <= '0;
				skip_q        <= 1'b1;
				begin_q       <= '0;
				prev_ff_q     <= 1'b0;
				last_nz_end_q <= '0;
			end else begin
				byte_index_q  <= idx_plus1;
				skip_q        <= skip_next;
				begin_q       <= begin_next;
				prev_ff_q     <= is_ff;
				last_nz_end_q <= tail_end;
			end
		end
	end

endmodule

// File: rtl/jefd_queue.sv
// Short queue of stretch candidates between the front and the back part.
// Depends on jefd_pkg.
`timescale 1ns / 1ps

module jefd_queue
	import jefd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frag_cand_t wr_cand,
	output logic       full,
	input  logic       pop,
	output logic       rd_valid,
	output frag_cand_t rd_cand
);

	frag_cand_t             slot_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCOUNT_BITS-1:0] count_q;

	assign full     = (count_q == QCOUNT_BITS'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cand  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCOUNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCOUNT_BITS'(1);
			end
		end
	end

endmodule

// File: rtl/jefd_back.sv
// Back part of the fragment detector: holds the minimum length, filters the
// candidates and forms the absolute start in the output register.
// Depends on jefd_pkg.
`timescale 1ns / 1ps

module jefd_back
	import jefd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [MINLEN_W-1:0] cfg_wr_data,
	input  logic                rd_valid,
	input  frag_cand_t          rd_cand,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [START_W-1:0]  out_start,
	output logic [LENGTH_W-1:0] out_length,
	output logic                out_tail
);

	logic [MINLEN_W-1:0]    min_len_q;
	logic                   valid_q;
	logic [START_W-1:0]     start_q;
	logic [LENGTH_W-1:0]    length_q;
	logic                   tail_q;

	logic                   mark_hit;
	logic                   tail_hit;
	logic [REGION_BITS-1:0] sel_begin;
	logic [REGION_BITS-1:0] sel_len;
	logic [OFFSET_BITS-1:0] abs_start;

	always_comb begin
		pop      = rd_valid && (!valid_q || out_ready);
		mark_hit = rd_cand.mark_ok &&
			(CMP_BITS'(rd_cand.brk_len) > CMP_BITS'(min_len_q));
		tail_hit = rd_cand.tail_ok &&
			(CMP_BITS'(rd_cand.tail_len) > CMP_BITS'(min_len_q));
		// A reported marker break takes the place of the tail.
		sel_begin = mark_hit ? rd_cand.mark_begin : rd_cand.tail_begin;
		sel_len   = mark_hit ? rd_cand.brk_len : rd_cand.tail_len;
		abs_start = rd_cand.base + OFFSET_BITS'(sel_begin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_FRAG_RESET;
			valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				min_len_q <= cfg_wr_data;
			end
			if (pop) begin
				valid_q <= mark_hit || tail_hit;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			start_q  <= START_W'(abs_start);
			length_q <= LENGTH_W'(sel_len);
			tail_q   <= !mark_hit;
		end
	end

	assign out_valid  = valid_q;
	assign out_start  = start_q;
	assign out_length = length_q;
	assign out_tail   = tail_q;

endmodule

// File: rtl/jefd_checker.sv
// Port-level checks for the JPEG entropy fragment detector, bound to the top
// level. Depends on jefd_pkg.
`timescale 1ns / 1ps

module jefd_checker
	import jefd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tready,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tuser
);

	// A stalled word keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// A reported fragment is longer than some minimum, so never empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:START_W] != '0))
		else $error("fragment of length zero reported");

	// Reset leaves no word on the master side.
	assert property (@(posedge clk)
		arst_n && $past(!arst_n) |-> !m_axis_tvalid)
		else $error("output valid right after reset");

	// The queue is empty after reset, so the slave side is ready at once.
	assert property (@(posedge clk)
		arst_n && $past(!arst_n) |-> s_axis_tready)
		else $error("input not ready right after reset");

endmodule

bind jpeg_entropy_fragment_detector jefd_checker u_jefd_checker (.*);

// File: dv/jpeg_entropy_fragment_detector_tb.sv
// Self-checking testbench for jpeg_entropy_fragment_detector: random and directed
// disk-region byte streams, a scan-state predictor and an in-order result check.
// Depends on jefd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module jpeg_entropy_fragment_detector_tb;
	import jefd_pkg::*;

	// One byte of a region as it travels on the slave stream.
	typedef struct {
		logic [BYTE_W-1:0]  data_byte;
		logic [START_W-1:0] region_base;
		logic               region_end;
	} scan_word_t;

	// One reported fragment as it travels on the master stream.
	typedef struct {
		logic [START_W-1:0]  start;
		logic [LENGTH_W-1:0] length;
		logic                is_tail;
	} fragment_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [MINLEN_W-1:0]    cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// tdata fields from bit 0 up: data_byte [7:0], region_base [55:8].
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	// tlast is region_end.
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// tdata fields from bit 0 up: frag_start [47:0], frag_length [79:48].
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// tuser field: is_tail [0].
	logic                   m_axis_tuser;

	// Bytes waiting to be sent and fragments waiting to be received.
	scan_word_t queued_bytes[$];
	fragment_t  pending_fragments[$];
	int         bytes_added = 0;
	int         errors = 0;

	// Random idling of both sides; switched off for quiet stretches and the end.
	bit idle_on = 1'b1;
	int gap_left = 0;
	int stall_left = 0;

	// Predicted scan state of the block and its copy of the minimum length.
	logic [REGION_BITS-1:0] scan_pos = '0;
	logic [REGION_BITS-1:0] stretch_from = '0;
	logic [REGION_BITS-1:0] zero_tail = '0;
	logic [OFFSET_BITS-1:0] region_origin = '0;
	logic                   in_lead_zeros = 1'b1;
	logic                   after_ff = 1'b0;
	logic [MINLEN_W-1:0]    min_length = MIN_FRAG_RESET;

	jpeg_entropy_fragment_detector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [START_W-1:0] random_offset();
		return START_W'({$urandom(), $urandom()});
	endfunction

	function automatic fragment_t fragment_at(logic [REGION_BITS-1:0] from,
		logic [REGION_BITS-1:0] len, logic tail);
		fragment_t f;
		f.start = region_origin + OFFSET_BITS'(from);
		f.length = len;
		f.is_tail = tail;
		return f;
	endfunction

	// Advances the predicted scan state by one accepted byte and queues the
	// fragment that the byte closes, if any. Lengths wrap at the counter width.
	task track_scan_byte(input scan_word_t w);
		logic [REGION_BITS-1:0] pos;
		logic [REGION_BITS-1:0] len;
		logic                   closed;
		pos = scan_pos;
		closed = 1'b0;
		if (pos == '0)
			region_origin = w.region_base;
		if (in_lead_zeros) begin
			if (w.data_byte == STUFF_BYTE)
				stretch_from = pos + 1'b1;
			else
				in_lead_zeros = 1'b0;
		end else if (after_ff && w.data_byte != STUFF_BYTE &&
				!(w.data_byte >= RESTART_FIRST && w.data_byte < RESTART_END)) begin
			// An invalid marker: the stretch ends just before the FF.
			len = pos - 1'b1 - stretch_from;
			if (len > min_length) begin
				pending_fragments.insert(pending_fragments.size(),
					fragment_at(stretch_from, len, 1'b0));
				closed = 1'b1;
			end
			stretch_from = pos;
		end
		after_ff = (w.data_byte == MARK_PREFIX);
		zero_tail = (w.data_byte == STUFF_BYTE) ? zero_tail + 1'b1 : '0;
		if (w.region_end) begin
			// The tail is dropped when a marker result came on the same byte.
			if (!closed && !in_lead_zeros) begin
				len = pos + 1'b1 - stretch_from - zero_tail;
				if (len > min_length)
					pending_fragments.insert(pending_fragments.size(),
						fragment_at(stretch_from, len, 1'b1));
			end
			scan_pos = '0;
			in_lead_zeros = 1'b1;
			stretch_from = '0;
			after_ff = 1'b0;
			zero_tail = '0;
		end else begin
			scan_pos = pos + 1'b1;
		end
	endtask

	task note_mismatch(input string field, input logic [63:0] want, input logic [63:0] got);
		errors++;
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// Sender: presents one word at a time from the queue, with random gaps.
	always @(posedge clk) begin : byte_sender
		scan_word_t w;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (queued_bytes.size() != 0) begin
				w = queued_bytes.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {w.region_base, w.data_byte};
				s_axis_tlast <= w.region_end;
				if (idle_on && $urandom_range(3) == 0)
					gap_left <= $urandom_range(1, 5);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: ready except during random stall bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: predicts on every accepted byte and checks every accepted result.
	always @(posedge clk) begin : stream_monitor
		scan_word_t w;
		fragment_t  got;
		fragment_t  want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				w.data_byte = s_axis_tdata[BYTE_W-1:0];
				w.region_base = s_axis_tdata[IN_TDATA_W-1:BYTE_W];
				w.region_end = s_axis_tlast;
				track_scan_byte(w);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.start = m_axis_tdata[START_W-1:0];
				got.length = m_axis_tdata[OUT_TDATA_W-1:START_W];
				got.is_tail = m_axis_tuser;
				if (pending_fragments.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected fragment, expected none, actual %0h/%0h/%0b",
						$time, got.start, got.length, got.is_tail);
				end else begin
					want = pending_fragments.pop_front();
					if (got.start !== want.start)
						note_mismatch("frag_start", 64'(want.start), 64'(got.start));
					if (got.length !== want.length)
						note_mismatch("frag_length", 64'(want.length), 64'(got.length));
					if (got.is_tail !== want.is_tail)
						note_mismatch("is_tail", 64'(want.is_tail), 64'(got.is_tail));
				end
			end
		end
	end

	task add_byte(input logic [BYTE_W-1:0] b, input logic [START_W-1:0] base, input logic last);
		scan_word_t w;
		w.data_byte = b;
		w.region_base = base;
		w.region_end = last;
		queued_bytes.insert(queued_bytes.size(), w);
		bytes_added++;
	endtask

	// Sends a region given byte by byte; the base rides on its first word and
	// the other words carry random offsets, which the block must ignore.
	task add_fixed_region(input logic [BYTE_W-1:0] seq[$], input logic [START_W-1:0] base);
		int k;
		for (k = 0; k < seq.size(); k++)
			add_byte(seq[k], (k == 0) ? base : random_offset(), k == seq.size() - 1);
	endtask

	// Builds a random region: mostly well-formed scan data with stuffing and
	// restart codes, some invalid markers, leading and trailing zero runs,
	// and now and then a region of zeros only.
	task add_region();
		logic [BYTE_W-1:0]  seq[$];
		logic [START_W-1:0] base;
		int                 k;
		int                 body;
		int                 pick;
		seq = {};
		case ($urandom_range(7))
			0: base = '1;
			1: base = '0;
			default: base = random_offset();
		endcase
		if ($urandom_range(15) == 0) begin
			body = $urandom_range(1, 6);
			for (k = 0; k < body; k++)
				seq.insert(seq.size(), STUFF_BYTE);
		end else begin
			if ($urandom_range(3) == 0)
				for (k = $urandom_range(1, 4); k > 0; k--)
					seq.insert(seq.size(), STUFF_BYTE);
			body = $urandom_range(1, 40);
			for (k = 0; k < body; k++) begin
				if ($urandom_range(99) < 10) begin
					seq.insert(seq.size(), MARK_PREFIX);
					pick = $urandom_range(9);
					if (pick < 6)
						seq.insert(seq.size(), STUFF_BYTE);
					else if (pick < 9)
						seq.insert(seq.size(), RESTART_FIRST + BYTE_W'($urandom_range(7)));
					else
						seq.insert(seq.size(), BYTE_W'($urandom_range(255)));
				end else begin
					seq.insert(seq.size(), BYTE_W'($urandom_range(254)));
				end
			end
			if ($urandom_range(3) == 0)
				for (k = $urandom_range(1, 4); k > 0; k--)
					seq.insert(seq.size(), STUFF_BYTE);
		end
		add_fixed_region(seq, base);
	endtask

	// Holds the stimulus until every queued byte is taken and every expected
	// fragment has arrived, then lets the block's pipeline settle.
	task wait_drained();
		@(posedge clk);
		while (queued_bytes.size() != 0 || s_axis_tvalid || pending_fragments.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task set_min_length(input logic [MINLEN_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		min_length = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [BYTE_W-1:0]  seq[$];
		int                 phase;
		int                 target;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed regions with a minimum of zero.
		set_min_length('0);
		// Start offset wrap, stuffing, both restart extremes, the first code past
		// them, and a marker break on the last byte that drops the tail.
		seq = '{8'h00, 8'h11, 8'hFF, 8'hD0, 8'h22, 8'hFF, 8'hD7, 8'hFF, 8'h00, 8'h33,
			8'hFF, 8'hD8};
		add_fixed_region(seq, '1);
		// A region of zeros only reports nothing.
		seq = '{8'h00, 8'h00, 8'h00};
		add_fixed_region(seq, random_offset());
		// A marker break, then a tail that loses its trailing zeros.
		seq = '{8'h44, 8'hFF, 8'h01, 8'h00, 8'h00};
		add_fixed_region(seq, '0);
		// A region of a single FF byte.
		seq = '{8'hFF};
		add_fixed_region(seq, random_offset());
		wait_drained();

		// Random phases, each at its own minimum; the last one runs without idling.
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_min_length(32'd1);
				1: set_min_length('1);
				2: set_min_length(MINLEN_W'($urandom_range(2, 12)));
				3: set_min_length('0);
				4: set_min_length(MINLEN_W'($urandom_range(0, 30)));
				5: set_min_length(32'd2);
				6: set_min_length(MIN_FRAG_RESET);
				default: set_min_length(MINLEN_W'($urandom_range(1, 6)));
			endcase
			idle_on = (phase != 2 && phase != 7);
			target = bytes_added + 200;
			while (bytes_added < target)
				add_region();
			wait_drained();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog, several times the slowest correct run.
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/jefd_pkg.sv
rtl/jefd_front.sv
rtl/jefd_queue.sv
rtl/jefd_back.sv
rtl/jpeg_entropy_fragment_detector.sv
rtl/jefd_checker.sv
dv/jpeg_entropy_fragment_detector_tb.sv
